// ----- sv/nptg_pkg.sv -----
// Shared types, constants and fixed-point helpers for the noise puff texel generator.
// Depends on nothing; imported by the top level, nptg_noise and nptg_alpha.
package nptg_pkg;

  typedef struct packed {
    logic [7:0] texel_col;
    logic [7:0] texel_row;
  } texel_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam logic [23:0] TINT_RESET = 24'hFFFFFF;

  // hash multipliers
  localparam logic [31:0] HASH_X = 32'd374761393;
  localparam logic [31:0] HASH_Y = 32'd668265263;
  localparam logic [31:0] HASH_S = 32'd1274126177;

  localparam logic [10:0] SEED_BASE = 11'd7;
  localparam logic [10:0] SEED_STEP = 11'd613;

  // three noise lanes: edge roughness, alpha mask, luminance
  localparam int NUM_NOISE = 3;
  localparam logic signed [19:0] NOISE_FREQ [NUM_NOISE] =
    '{20'sd117965, 20'sd203162, 20'sd157286};
  localparam logic signed [23:0] NOISE_OFF_X [NUM_NOISE] =
    '{24'sd196608, -24'sd393216, 24'sd72090};
  localparam logic signed [23:0] NOISE_OFF_Y [NUM_NOISE] =
    '{-24'sd65536, 24'sd262144, -24'sd216269};
  localparam logic [10:0] NOISE_SEED_OFF [NUM_NOISE] = '{11'd0, 11'd37, 11'd71};

  // Q16 constants of the alpha and colour path
  localparam logic [15:0] ROUGH_GAIN = 16'd19661;
  localparam logic [16:0] DISC_EDGE  = 17'd60293;
  localparam logic [15:0] RAMP_DIV   = 16'd43254;
  localparam logic [16:0] RAMP_RECIP = 17'd99296;  // floor(2^32 / RAMP_DIV)
  localparam logic [16:0] MASK_BASE  = 17'd40632;
  localparam logic [15:0] MASK_GAIN  = 16'd36045;
  localparam logic [16:0] LUM_BASE   = 17'd51118;
  localparam logic [15:0] LUM_GAIN   = 16'd14418;
  localparam logic [16:0] Q16_ONE    = 17'd65536;

  // smoothstep, first half: t*t in Q16
  function automatic logic [17:0] smooth_sq(input logic [16:0] t);
    logic [33:0] p;
    p = 34'(t) * 34'(t);
    return p[33:16];
  endfunction

  // smoothstep, second half: tt * (3 - 2t) in Q16
  function automatic logic [17:0] smooth_mix(input logic [17:0] tt, input logic [16:0] t);
    logic [17:0] fac;
    logic [35:0] p;
    fac = 18'd196608 - {t, 1'b0};
    p = 36'(tt) * 36'(fac);
    return p[33:16];
  endfunction

endpackage

// ----- sv/noise_puff_texel_generator.sv -----
// Top level of the noise puff texel generator: input stages, noise lanes, radius root,
// alpha path and the output register. Depends on nptg_pkg, nptg_sqrt, nptg_noise, nptg_alpha.
//
// Usage:
//   texel channel  - texel_valid/texel_ready beats carry one atlas coordinate
//                    (column, row) of a 2x2 atlas of TILE_SIZE-square tiles.
//   pixel channel  - pixel_valid/pixel_ready beats carry alpha, red, green, blue.
//   cfg_we/cfg_wdata write the 24-bit tint (red low byte, blue high byte);
//   write it only while no beat is in flight.
// One texel enters per cycle while no finished pixel is held by pixel_ready; the
// rate is set by the fully pipelined datapath (6-stage square root and noise
// lanes, 8-stage alpha path) with no shared unit.
// Reset (synchronous, active high) empties the pipeline and sets the tint to white.
// When the receiver holds pixel_ready low with a pixel waiting, the whole pipeline
// freezes and texel_ready drops in the same cycle; nothing is lost or repeated.
// Valid bits travel alongside the datapath registers, so bubbles are free.
module noise_puff_texel_generator import nptg_pkg::*; #(
  parameter int TILE_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        texel_valid,
  output logic        texel_ready,
  input  texel_t      texel,
  output logic        pixel_valid,
  input  logic        pixel_ready,
  output pixel_t      pixel,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  localparam int TS_LOG = $clog2(TILE_SIZE);
  localparam int NSTG   = 18;

  logic [NSTG:1] vld;
  logic          en;
  logic [23:0]   tint;

  // advance everything unless the output beat is stuck
  assign en          = !vld[NSTG] || pixel_ready;
  assign texel_ready = en;
  assign pixel_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-1:1], texel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tint <= TINT_RESET;
    end else if (cfg_we) begin
      tint <= cfg_wdata;
    end
  end

  // stage 1: local coordinate to Q16 in -1..1, quadrant seed
  logic [9:0]         col_ext, row_ext;
  logic [TS_LOG-1:0]  lx, ly;
  logic [16:0]        odd_x, odd_y;
  logic [1:0]         quad;
  logic signed [17:0] s1_nx, s1_ny;
  logic [10:0]        s1_seed;

  assign col_ext = {2'b0, texel.texel_col};
  assign row_ext = {2'b0, texel.texel_row};
  assign lx      = col_ext[TS_LOG-1:0];
  assign ly      = row_ext[TS_LOG-1:0];
  assign quad    = {row_ext[TS_LOG], col_ext[TS_LOG]};
  // (2x+1)/TILE_SIZE in Q16 is a plain shift for a power-of-two tile
  assign odd_x   = 17'({lx, 1'b1}) << (16 - TS_LOG);
  assign odd_y   = 17'({ly, 1'b1}) << (16 - TS_LOG);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_nx   <= $signed({1'b0, odd_x}) - 18'sd65536;
      s1_ny   <= $signed({1'b0, odd_y}) - 18'sd65536;
      s1_seed <= 11'(quad) * SEED_STEP + SEED_BASE;
    end
  end

  // stage 2: squares for the radius, scaled coordinates for each noise lane
  // stage 3: radius sum, lattice coordinates and lane seeds
  logic signed [35:0] s2_sqx, s2_sqy;
  logic [10:0]        s2_seed;
  logic [33:0]        s3_v;
  logic signed [23:0] s3_px   [NUM_NOISE];
  logic signed [23:0] s3_py   [NUM_NOISE];
  logic [10:0]        s3_seed [NUM_NOISE];
  logic [16:0]        noise_n [NUM_NOISE];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx  <= 36'(s1_nx) * 36'(s1_nx);
      s2_sqy  <= 36'(s1_ny) * 36'(s1_ny);
      s2_seed <= s1_seed;
      s3_v    <= s2_sqx[33:0] + s2_sqy[33:0];
    end
  end

  for (genvar i = 0; i < NUM_NOISE; i++) begin : g_lane
    logic signed [37:0] s2_px, s2_py, shx, shy;

    assign shx = s2_px >>> 16;
    assign shy = s2_py >>> 16;

    always_ff @(posedge clk) begin
      if (en) begin
        s2_px      <= 38'(s1_nx) * 38'(NOISE_FREQ[i]);
        s2_py      <= 38'(s1_ny) * 38'(NOISE_FREQ[i]);
        s3_px[i]   <= $signed(shx[23:0]) + NOISE_OFF_X[i];
        s3_py[i]   <= $signed(shy[23:0]) + NOISE_OFF_Y[i];
        s3_seed[i] <= s2_seed + NOISE_SEED_OFF[i];
      end
    end

    // stages 4 to 9
    nptg_noise u_noise (
      .clk  (clk),
      .en   (en),
      .px   (s3_px[i]),
      .py   (s3_py[i]),
      .seed (s3_seed[i]),
      .n    (noise_n[i])
    );
  end

  // stages 4 to 9: radius
  logic [16:0] radius;

  nptg_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (s3_v),
    .root (radius)
  );

  // stages 10 to 17: alpha
  logic [16:0] alpha_q16;

  nptg_alpha u_alpha (
    .clk     (clk),
    .en      (en),
    .r0      (radius),
    .rough_n (noise_n[0]),
    .mask_n  (noise_n[1]),
    .a       (alpha_q16)
  );

  // stage 10: luminance, then hold it alongside the alpha path
  logic [32:0] lp;
  logic [16:0] lum_q [8];

  assign lp = 33'(noise_n[2]) * 33'(LUM_GAIN);

  always_ff @(posedge clk) begin
    if (en) begin
      lum_q[0] <= LUM_BASE + lp[32:16];
      for (int k = 1; k < 8; k++) begin
        lum_q[k] <= lum_q[k-1];
      end
    end
  end

  // stage 18: bytes out
  function automatic logic [7:0] to_byte(input logic [7:0] tb, input logic [16:0] lum);
    logic [24:0] p;
    p = 25'(tb) * 25'(lum);
    return (p[24:16] > 9'd255) ? 8'd255 : p[23:16];
  endfunction

  logic [24:0] ap;

  assign ap = 25'(alpha_q16) * 25'd255;

  always_ff @(posedge clk) begin
    if (en) begin
      pixel.alpha <= (ap[24:16] > 9'd255) ? 8'd255 : ap[23:16];
      pixel.red   <= to_byte(tint[7:0], lum_q[7]);
      pixel.green <= to_byte(tint[15:8], lum_q[7]);
      pixel.blue  <= to_byte(tint[23:16], lum_q[7]);
    end
  end

  // reset leaves no pixel beat pending
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !pixel_valid)
    else $error("pixel beat offered right after reset");

  // the input side only stalls because a finished pixel is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !texel_ready |-> (pixel_valid && !pixel_ready))
    else $error("texel channel stalled without an output stall");

  // a held pixel freezes the whole valid chain
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> $stable(vld))
    else $error("pipeline moved during an output stall");

endmodule

// ----- sv/nptg_sqrt.sv -----
// Pipelined 17-bit integer square root of a 34-bit value, three result bits per stage.
// Depends on nothing; used by the top level for the texel radius.
module nptg_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] v,
  output logic [16:0] root
);

  localparam int NSTG     = 6;
  localparam int BITS_PER = 3;

  logic [33:0] rem_q  [NSTG];
  logic [16:0] root_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [33:0] rem_i, rem_c;
    logic [16:0] root_i, root_c;

    if (s == 0) begin : g_first
      assign rem_i  = v;
      assign root_i = '0;
    end else begin : g_next
      assign rem_i  = rem_q[s-1];
      assign root_i = root_q[s-1];
    end

    always_comb begin
      logic [33:0] trial;
      int b;
      rem_c  = rem_i;
      root_c = root_i;
      trial  = '0;
      for (int j = 0; j < BITS_PER; j++) begin
        b = 16 - BITS_PER * s - j;
        if (b >= 0) begin
          // (root + 2^b)^2 - root^2
          trial = (34'(root_c) << (b + 1)) | (34'd1 << (2 * b));
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = root_c | (17'd1 << b);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_c;
        root_q[s] <= root_c;
      end
    end
  end

  assign root = root_q[NSTG-1];

endmodule

// ----- sv/nptg_noise.sv -----
// Six-stage hashed 2D value noise with smoothstep blend, Q16 in and out.
// Depends on nptg_pkg for the hash constants and smoothstep helpers.
module nptg_noise import nptg_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [23:0] px,
  input  logic signed [23:0] py,
  input  logic [10:0]        seed,
  output logic [16:0]        n
);

  function automatic logic [16:0] lerp(input logic [16:0] a, input logic [16:0] b,
                                       input logic [16:0] t);
    logic signed [17:0] diff;
    logic signed [17:0] ts;
    logic signed [35:0] p;
    logic signed [35:0] r;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    ts   = $signed({1'b0, t});
    p    = diff * ts;
    r    = $signed({19'b0, a}) + (p >>> 16);
    return r[16:0];
  endfunction

  logic [31:0] xi0, xi1, yi0, yi1;

  assign xi0 = {{24{px[23]}}, px[23:16]};
  assign yi0 = {{24{py[23]}}, py[23:16]};
  assign xi1 = xi0 + 32'd1;
  assign yi1 = yi0 + 32'd1;

  // stage 1: lattice products, fraction squares
  logic [31:0] ax0, ax1, by0, by1, cs;
  logic [17:0] ttx, tty;
  logic [15:0] xf1, yf1;

  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= xi0 * HASH_X;
      ax1 <= xi1 * HASH_X;
      by0 <= yi0 * HASH_Y;
      by1 <= yi1 * HASH_Y;
      cs  <= {21'b0, seed} * HASH_S;
      ttx <= smooth_sq({1'b0, px[15:0]});
      tty <= smooth_sq({1'b0, py[15:0]});
      xf1 <= px[15:0];
      yf1 <= py[15:0];
    end
  end

  // stage 2: corner sums and first mix; stage 3: second multiply
  // stage 4: fold to a 16-bit value scaled to Q16
  logic [31:0] mix2 [4];
  logic [31:0] mul3 [4];
  logic [16:0] c4   [4];
  logic [16:0] u2, v2, u3, v3, u4, v4;

  for (genvar k = 0; k < 4; k++) begin : g_corner
    logic [31:0] sum;
    logic [15:0] h;
    assign sum = ((k % 2) == 1 ? ax1 : ax0) + ((k / 2) == 1 ? by1 : by0) + cs;
    assign h   = mul3[k][15:0] ^ mul3[k][31:16];

    always_ff @(posedge clk) begin
      if (en) begin
        mix2[k] <= sum ^ 32'($signed(sum) >>> 13);
        mul3[k] <= mix2[k] * HASH_S;
        c4[k]   <= {1'b0, h} + {16'b0, h[15]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2 <= 17'(smooth_mix(ttx, {1'b0, xf1}));
      v2 <= 17'(smooth_mix(tty, {1'b0, yf1}));
      u3 <= u2;
      v3 <= v2;
      u4 <= u3;
      v4 <= v3;
    end
  end

  // stage 5: blend along x; stage 6: blend along y
  logic [16:0] top5, bot5, v5;

  always_ff @(posedge clk) begin
    if (en) begin
      top5 <= lerp(c4[0], c4[1], u4);
      bot5 <= lerp(c4[2], c4[3], u4);
      v5   <= v4;
      n    <= lerp(top5, bot5, v5);
    end
  end

endmodule

// ----- sv/nptg_alpha.sv -----
// Eight-stage alpha path: roughened radius, disc ramp, smoothstep and noise mask.
// Depends on nptg_pkg for Q16 constants and smoothstep helpers.
module nptg_alpha import nptg_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] r0,
  input  logic [16:0] rough_n,
  input  logic [16:0] mask_n,
  output logic [16:0] a
);

  // stage 1: roughness factor and mask factor
  logic signed [17:0] nc;
  logic signed [34:0] fp, fs;
  logic [32:0]        mp;
  logic [16:0]        f1, r1, m1;

  assign nc = $signed({1'b0, rough_n}) - 18'sd32768;
  assign fp = 35'(nc) * $signed({19'b0, ROUGH_GAIN});
  assign fs = (fp >>> 16) + 35'sd65536;
  assign mp = 33'(mask_n) * 33'(MASK_GAIN);

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= fs[16:0];
      r1 <= r0;
      m1 <= MASK_BASE + mp[32:16];
    end
  end

  // stage 2: scaled radius
  logic [33:0] rp;
  logic [16:0] r2, m2;

  assign rp = 34'(r1) * 34'(f1);

  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= rp[32:16];
      m2 <= m1;
    end
  end

  // stage 3: distance inside the edge, reciprocal multiply
  logic signed [17:0] d;
  logic [32:0]        dq3;
  logic [15:0]        d3;
  logic               pos3, sat3;
  logic [16:0]        m3;

  assign d = $signed({1'b0, DISC_EDGE}) - $signed({1'b0, r2});

  always_ff @(posedge clk) begin
    if (en) begin
      dq3  <= 33'(d[15:0]) * 33'(RAMP_RECIP);
      d3   <= d[15:0];
      pos3 <= d > 18'sd0;
      sat3 <= d >= $signed({2'b0, RAMP_DIV});
      m3   <= m2;
    end
  end

  // stage 4: back-multiply the quotient estimate
  logic [15:0] qe4, d4;
  logic [31:0] prod4;
  logic        pos4, sat4;
  logic [16:0] m4;

  always_ff @(posedge clk) begin
    if (en) begin
      qe4   <= dq3[31:16];
      prod4 <= 32'(dq3[31:16]) * 32'(RAMP_DIV);
      d4    <= d3;
      pos4  <= pos3;
      sat4  <= sat3;
      m4    <= m3;
    end
  end

  // stage 5: correct the estimate by one step, clamp the ramp
  logic [31:0] rem5;
  logic [16:0] q5, a5, m5;

  assign rem5 = {d4, 16'b0} - prod4;
  assign q5   = {1'b0, qe4} + ((rem5 >= 32'(RAMP_DIV)) ? 17'd1 : 17'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!pos4) begin
        a5 <= '0;
      end else if (sat4) begin
        a5 <= Q16_ONE;
      end else begin
        a5 <= q5;
      end
      m5 <= m4;
    end
  end

  // stages 6 and 7: smoothstep
  logic [17:0] tt6, a7;
  logic [16:0] t6, m6, m7;

  always_ff @(posedge clk) begin
    if (en) begin
      tt6 <= smooth_sq(a5);
      t6  <= a5;
      m6  <= m5;
      a7  <= smooth_mix(tt6, t6);
      m7  <= m6;
    end
  end

  // stage 8: noise mask, saturate at one
  logic [34:0] ap;

  assign ap = 35'(a7) * 35'(m7);

  always_ff @(posedge clk) begin
    if (en) begin
      a <= (ap[34:16] > 19'(Q16_ONE)) ? Q16_ONE : ap[32:16];
    end
  end

endmodule
